@@ hw/rtl/gte_pkg.sv @@
// shared constants, tables and types for the geodetic to ecef converter
`timescale 1ns / 1ps
`default_nettype none

package gte_pkg;

    // pi in q60 and the degree scale applied to 2^-23 degree angles
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic signed [63:0] DEG_K = 64'(PI_Q60 / 64'd90);

    // ellipsoid and series constants
    localparam logic signed [63:0] E2_Q62    = 64'sd30872378602568713;
    localparam logic signed [63:0] ONE_Q62   = 64'sh4000000000000000;
    localparam logic signed [63:0] B2_Q62    = ONE_Q62 - E2_Q62;
    localparam logic signed [63:0] INV_GAIN  = 64'sd1400229935014726477;
    localparam logic signed [63:0] A_MM      = 64'sd6378137000;

    // angle folding limits
    localparam logic signed [32:0] DEG90  = 33'sd754974720;
    localparam logic signed [32:0] DEG180 = 33'sd1509949440;

    // output saturation limit in mm
    localparam logic signed [33:0] OUT_LIM = 34'sd8000000000;

    // binomial series of 1/sqrt(1-d) in q62
    localparam logic signed [63:0] SERIES [9] = '{
        64'sh4000000000000000,
        64'sd1 << 61,
        64'sd3 << 59,
        64'sd5 << 58,
        64'sd35 << 55,
        64'sd63 << 54,
        64'sd231 << 52,
        64'sd429 << 51,
        64'sd6435 << 47
    };

    // sine and cosine of latitude and longitude travelling together
    typedef struct packed {
        logic signed [63:0] clat;
        logic signed [63:0] slat;
        logic signed [63:0] clon;
        logic signed [63:0] slon;
    } sc_t;

    // atan(2^-i) in q2.61 from the truncated power series, elaboration only
    function automatic logic [63:0] atan_q61(input int unsigned i);
        logic [63:0] sum;
        logic [63:0] term;
        int unsigned k;
        sum = '0;
        if (i == 0)
        begin
            return PI_Q60 >> 1;
        end
        for (k = 0; (2 * k + 1) * i <= 61; k++)
        begin
            term = (64'd1 << (61 - (2 * k + 1) * i)) / 64'(2 * k + 1);
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gte_mul.sv @@
// pipelined 64 by 64 magnitude multiplier with shift, truncation and sign
`timescale 1ns / 1ps
`default_nettype none

module gte_mul #(
    parameter int SHIFT = 61
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [63:0] a,
    input  wire logic signed [63:0] b,
    output logic signed [63:0]      p
);

    logic [63:0]  am_reg;
    logic [63:0]  bm_reg;
    logic         neg0_reg;
    logic [63:0]  ll_reg;
    logic [63:0]  lh_reg;
    logic [63:0]  hl_reg;
    logic [63:0]  hh_reg;
    logic         neg1_reg;
    logic [127:0] prod;
    logic [63:0]  r_reg;
    logic         neg2_reg;
    logic signed [63:0] p_reg;

    // magnitudes and result sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am_reg   <= a[63] ? (~a + 64'd1) : a;
            bm_reg   <= b[63] ? (~b + 64'd1) : b;
            neg0_reg <= a[63] ^ b[63];
        end
    end

    // four 32 by 32 partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg   <= 64'(am_reg[31:0])  * 64'(bm_reg[31:0]);
            lh_reg   <= 64'(am_reg[31:0])  * 64'(bm_reg[63:32]);
            hl_reg   <= 64'(am_reg[63:32]) * 64'(bm_reg[31:0]);
            hh_reg   <= 64'(am_reg[63:32]) * 64'(bm_reg[63:32]);
            neg1_reg <= neg0_reg;
        end
    end

    // partial product sum and shift
    assign prod = 128'(ll_reg) + (128'(lh_reg) << 32) + (128'(hl_reg) << 32)
                + (128'(hh_reg) << 64);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= prod[SHIFT + 63:SHIFT];
            neg2_reg <= neg1_reg;
        end
    end

    // drop the top bit and apply the sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= neg2_reg ? -signed'({1'b0, r_reg[62:0]}) : signed'({1'b0, r_reg[62:0]});
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

@@ hw/rtl/gte_cordic.sv @@
// rotation mode cordic giving sine and cosine of a folded angle
`timescale 1ns / 1ps
`default_nettype none

module gte_cordic #(
    parameter int STAGES = 32
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [63:0] angle,
    input  wire logic               flip,
    output logic signed [63:0]      cosine,
    output logic signed [63:0]      sine
);

    logic signed [63:0] x_reg [STAGES];
    logic signed [63:0] y_reg [STAGES];
    logic signed [63:0] z_reg [STAGES];
    logic               f_reg [STAGES];
    logic signed [63:0] cos_reg;
    logic signed [63:0] sin_reg;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [63:0] xi;
        logic signed [63:0] yi;
        logic signed [63:0] zi;
        logic               fi;

        // stage inputs
        if (i == 0)
        begin : g_first
            assign xi = gte_pkg::INV_GAIN;
            assign yi = '0;
            assign zi = angle;
            assign fi = flip;
        end
        else
        begin : g_next
            assign xi = x_reg[i - 1];
            assign yi = y_reg[i - 1];
            assign zi = z_reg[i - 1];
            assign fi = f_reg[i - 1];
        end

        // one micro-rotation, or a plain delay past the useful stages
        if (i < 62)
        begin : g_rot
            localparam logic signed [63:0] ATAN = signed'(gte_pkg::atan_q61(i));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!zi[63])
                    begin
                        x_reg[i] <= xi - (yi >>> i);
                        y_reg[i] <= yi + (xi >>> i);
                        z_reg[i] <= zi - ATAN;
                    end
                    else
                    begin
                        x_reg[i] <= xi + (yi >>> i);
                        y_reg[i] <= yi - (xi >>> i);
                        z_reg[i] <= zi + ATAN;
                    end
                    f_reg[i] <= fi;
                end
            end
        end
        else
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i] <= xi;
                    y_reg[i] <= yi;
                    z_reg[i] <= zi;
                    f_reg[i] <= fi;
                end
            end
        end
    end

    // quadrant correction for folded angles
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= f_reg[STAGES - 1] ? -x_reg[STAGES - 1] : x_reg[STAGES - 1];
            sin_reg <= f_reg[STAGES - 1] ? -y_reg[STAGES - 1] : y_reg[STAGES - 1];
        end
    end

    assign cosine = cos_reg;
    assign sine   = sin_reg;

endmodule

`default_nettype wire

@@ hw/rtl/geodetic_to_ecef.sv @@
// wgs84 geodetic position to earth-centred earth-fixed coordinates
// throughput: one position per cycle; the whole pipeline advances together
// and holds while a finished result waits on the output
// reset clears only the valid bits of the pipeline; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module geodetic_to_ecef #(
    parameter int CORDIC_STAGES = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pos_valid,
    output logic                    pos_ready,
    input  wire logic signed [30:0] latitude,
    input  wire logic signed [31:0] longitude,
    input  wire logic signed [30:0] altitude,
    output logic                    ecef_valid,
    input  wire logic               ecef_ready,
    output logic signed [33:0]      ecef_x,
    output logic signed [33:0]      ecef_y,
    output logic signed [33:0]      ecef_z
);

    localparam int T_SC    = CORDIC_STAGES + 6;
    localparam int TOTAL   = T_SC + 67;
    localparam int ALT_DLY = T_SC + 56;
    localparam int SC_DLY  = 61;

    logic               en;
    logic               valid_reg [TOTAL];

    logic signed [32:0] lat_w;
    logic signed [32:0] lon_w;
    logic signed [32:0] lat_f;
    logic signed [32:0] lon_f;
    logic               lat_flip;
    logic               lon_flip;
    logic signed [63:0] lat_u_reg;
    logic signed [63:0] lon_u_reg;
    logic [1:0]         flip_dly_reg [5];
    logic signed [30:0] alt_dly_reg [ALT_DLY];

    logic signed [63:0] zlat_w;
    logic signed [63:0] zlon_w;
    gte_pkg::sc_t       sc_w;
    gte_pkg::sc_t       sc_dly_reg [SC_DLY];

    logic signed [63:0] sq_w;
    logic signed [63:0] d_w;
    logic signed [63:0] hm_w [8];
    logic signed [63:0] hg_reg [8];
    logic signed [63:0] hd_reg [8][5];
    logic signed [63:0] n20_w;
    logic signed [63:0] nz20_w;
    logic signed [63:0] n20_dly_reg [4];
    logic signed [63:0] alt20;
    logic signed [63:0] rxy_reg;
    logic signed [63:0] rz_reg;
    logic signed [63:0] t_w;
    logic signed [63:0] zp_w;
    logic signed [63:0] zp_dly_reg [4];
    logic signed [63:0] v_w [3];
    logic [63:0]        fm_reg [3];
    logic               fn_reg [3];
    logic [64:0]        rnd [3];
    logic [33:0]        sat [3];
    logic signed [33:0] out_reg [3];

    // pipeline advances unless a result waits on the output
    assign en         = !valid_reg[TOTAL - 1] || ecef_ready;
    assign pos_ready  = en;
    assign ecef_valid = valid_reg[TOTAL - 1];

    // valid bits travelling with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TOTAL; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= pos_valid;
            for (int k = 1; k < TOTAL; k++)
                valid_reg[k] <= valid_reg[k - 1];
        end
    end

    // fold angles beyond a quarter turn into range
    always_comb
    begin
        lat_w    = 33'(latitude);
        lon_w    = 33'(longitude);
        lat_f    = lat_w;
        lon_f    = lon_w;
        lat_flip = 1'b0;
        lon_flip = 1'b0;
        if (lat_w > gte_pkg::DEG90)
        begin
            lat_f    = lat_w - gte_pkg::DEG180;
            lat_flip = 1'b1;
        end
        else if (lat_w < -gte_pkg::DEG90)
        begin
            lat_f    = lat_w + gte_pkg::DEG180;
            lat_flip = 1'b1;
        end
        if (lon_w > gte_pkg::DEG90)
        begin
            lon_f    = lon_w - gte_pkg::DEG180;
            lon_flip = 1'b1;
        end
        else if (lon_w < -gte_pkg::DEG90)
        begin
            lon_f    = lon_w + gte_pkg::DEG180;
            lon_flip = 1'b1;
        end
    end

    // input register, flip and altitude delay lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat_u_reg       <= 64'(lat_f);
            lon_u_reg       <= 64'(lon_f);
            flip_dly_reg[0] <= {lat_flip, lon_flip};
            for (int k = 1; k < 5; k++)
                flip_dly_reg[k] <= flip_dly_reg[k - 1];
            alt_dly_reg[0] <= altitude;
            for (int k = 1; k < ALT_DLY; k++)
                alt_dly_reg[k] <= alt_dly_reg[k - 1];
        end
    end

    // degrees to radians in q2.61
    gte_mul #(.SHIFT(23)) u_zlat (
        .clk(clk), .en(en), .a(lat_u_reg), .b(gte_pkg::DEG_K), .p(zlat_w)
    );
    gte_mul #(.SHIFT(23)) u_zlon (
        .clk(clk), .en(en), .a(lon_u_reg), .b(gte_pkg::DEG_K), .p(zlon_w)
    );

    // sine and cosine
    gte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lat (
        .clk(clk), .en(en), .angle(zlat_w), .flip(flip_dly_reg[4][1]),
        .cosine(sc_w.clat), .sine(sc_w.slat)
    );
    gte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lon (
        .clk(clk), .en(en), .angle(zlon_w), .flip(flip_dly_reg[4][0]),
        .cosine(sc_w.clon), .sine(sc_w.slon)
    );

    // trig values wait for the radius
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_dly_reg[0] <= sc_w;
            for (int k = 1; k < SC_DLY; k++)
                sc_dly_reg[k] <= sc_dly_reg[k - 1];
        end
    end

    // d = e2 sin^2 lat
    gte_mul #(.SHIFT(60)) u_sq (
        .clk(clk), .en(en), .a(sc_w.slat), .b(sc_w.slat), .p(sq_w)
    );
    gte_mul #(.SHIFT(62)) u_d (
        .clk(clk), .en(en), .a(sq_w), .b(gte_pkg::E2_Q62), .p(d_w)
    );

    // horner evaluation of 1/sqrt(1-d), one step per multiply and add
    for (genvar j = 0; j < 8; j++)
    begin : g_horner
        logic signed [63:0] g_in;
        logic signed [63:0] d_in;

        if (j == 0)
        begin : g_first
            assign g_in = gte_pkg::SERIES[8];
            assign d_in = d_w;
        end
        else
        begin : g_next
            assign g_in = hg_reg[j - 1];
            assign d_in = hd_reg[j - 1][4];
        end

        gte_mul #(.SHIFT(62)) u_hm (
            .clk(clk), .en(en), .a(g_in), .b(d_in), .p(hm_w[j])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hg_reg[j]    <= hm_w[j] + gte_pkg::SERIES[7 - j];
                hd_reg[j][0] <= d_in;
                for (int k = 1; k < 5; k++)
                    hd_reg[j][k] <= hd_reg[j][k - 1];
            end
        end
    end

    // prime vertical radius and its polar scaled form, mm with 20 fraction bits
    gte_mul #(.SHIFT(42)) u_n (
        .clk(clk), .en(en), .a(gte_pkg::A_MM), .b(hg_reg[7]), .p(n20_w)
    );
    gte_mul #(.SHIFT(62)) u_nz (
        .clk(clk), .en(en), .a(n20_w), .b(gte_pkg::B2_Q62), .p(nz20_w)
    );

    assign alt20 = {{13{alt_dly_reg[ALT_DLY - 1][30]}}, alt_dly_reg[ALT_DLY - 1], 20'b0};

    // add the height
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n20_dly_reg[0] <= n20_w;
            for (int k = 1; k < 4; k++)
                n20_dly_reg[k] <= n20_dly_reg[k - 1];
            rxy_reg <= n20_dly_reg[3] + alt20;
            rz_reg  <= nz20_w + alt20;
        end
    end

    // projections onto the axes
    gte_mul #(.SHIFT(61)) u_t (
        .clk(clk), .en(en), .a(rxy_reg), .b(sc_dly_reg[56].clat), .p(t_w)
    );
    gte_mul #(.SHIFT(61)) u_zp (
        .clk(clk), .en(en), .a(rz_reg), .b(sc_dly_reg[56].slat), .p(zp_w)
    );
    gte_mul #(.SHIFT(61)) u_x (
        .clk(clk), .en(en), .a(t_w), .b(sc_dly_reg[60].clon), .p(v_w[0])
    );
    gte_mul #(.SHIFT(61)) u_y (
        .clk(clk), .en(en), .a(t_w), .b(sc_dly_reg[60].slon), .p(v_w[1])
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zp_dly_reg[0] <= zp_w;
            for (int k = 1; k < 4; k++)
                zp_dly_reg[k] <= zp_dly_reg[k - 1];
        end
    end

    assign v_w[2] = zp_dly_reg[3];

    // round half away from zero to whole mm and saturate
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            rnd[a] = (65'(fm_reg[a]) + 65'd524288) >> 20;
            if (rnd[a] > 65'(gte_pkg::OUT_LIM))
                sat[a] = gte_pkg::OUT_LIM;
            else
                sat[a] = rnd[a][33:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                fm_reg[a]  <= v_w[a][63] ? (~v_w[a] + 64'd1) : v_w[a];
                fn_reg[a]  <= v_w[a][63];
                out_reg[a] <= fn_reg[a] ? -signed'(sat[a]) : signed'(sat[a]);
            end
        end
    end

    assign ecef_x = out_reg[0];
    assign ecef_y = out_reg[1];
    assign ecef_z = out_reg[2];

    // input is held back only while a finished result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !pos_ready |-> (ecef_valid && !ecef_ready))
    else $error("input stalled without a waiting result");

    // an empty output never stalls the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        !ecef_valid |-> pos_ready)
    else $error("pipeline stalled with empty output");

    // results stay within the saturation limit
    assert property (@(posedge clk) disable iff (!rst_n)
        ecef_valid |-> (ecef_x <= gte_pkg::OUT_LIM && ecef_x >= -gte_pkg::OUT_LIM
                     && ecef_y <= gte_pkg::OUT_LIM && ecef_y >= -gte_pkg::OUT_LIM
                     && ecef_z <= gte_pkg::OUT_LIM && ecef_z >= -gte_pkg::OUT_LIM))
    else $error("coordinate beyond saturation limit");

endmodule

`default_nettype wire
